FILE: hdl/rsa_pkg.sv
package rsa_pkg;

    // Operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DECL  = 2'd1;
    localparam logic [1:0] OP_MAP   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REDECL = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Input transaction payload
    typedef struct packed {
        logic [1:0]  op;
        logic        primary;
        logic [3:0]  var_no;
        logic [63:0] name_low;
        logic [31:0] name_high;
        logic [15:0] owner_code;
        logic [15:0] rel_status;
    } t_in;

    // Result transaction payload
    typedef struct packed {
        logic [3:0] slot;
        logic [4:0] mapped_var;
        logic [1:0] status;
    } t_out;

endpackage

FILE: hdl/rsa_in_if.sv
interface rsa_in_if;
    import rsa_pkg::*;

    logic valid;
    logic ready;
    t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/rsa_out_if.sv
interface rsa_out_if;
    import rsa_pkg::*;

    logic valid;
    logic ready;
    t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/range_slot_allocator_remap_top.sv
// A transaction accepted into r_in runs its S_EXEC step, which registers the result in r_out;
//   the result can be taken from the output once r_out_valid is set.
// Transactions do not overlap: a new one is taken only back in S_IDLE, after the remap memory
//   read at accept and the read-modify-write step. A result held on the output blocks input.
// Reset (synchronous, active low): all slots free, every remap entry reads as no mapping,
//   output empty. The name/owner/status store is not cleared and holds garbage until written.
module range_slot_allocator_remap_top #(
    parameter int MAX_VAR    = 15,
    parameter int NAME_BYTES = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsa_in_if.sink    i_in,
    rsa_out_if.source o_out
);
    import rsa_pkg::*;

    localparam int NSLOTS = MAX_VAR + 1;
    localparam int SW     = $clog2(NSLOTS);
    localparam int RW     = $clog2(NSLOTS + 1);
    localparam int NW     = 8 * NAME_BYTES;
    localparam int EW     = NW + 32;
    localparam logic [RW-1:0] FULL_MARK = RW'(NSLOTS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state              r_state, n_state;
    t_in                 r_in;
    logic [NSLOTS-1:0]   r_slot_used, n_slot_used;
    logic [NSLOTS-1:0]   r_remap_wr, n_remap_wr;   // entry written since last clear
    logic                r_clr_full, n_clr_full;   // last clear was primary
    logic [RW-1:0]       r_rd;
    logic [SW-1:0]       r_tgt, n_tgt;
    t_out                r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [RW-1:0]       remap_mem [NSLOTS];
    logic [EW-1:0]       entry_mem [NSLOTS];

    logic                w_accept;
    logic                w_inr;
    logic [SW-1:0]       w_idx;
    logic                w_set;
    logic [SW-1:0]       w_low;
    logic                w_found;
    logic                w_remap_we;
    logic                w_entry_we;
    logic [95:0]         w_name;

    assign i_in.ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign w_name      = {r_in.name_high, r_in.name_low};

    // Decode of the held transaction against current table state
    always_comb begin
        w_inr = (32'(r_in.var_no) < 32'(NSLOTS));
        w_idx = SW'(r_in.var_no);
        w_set = r_remap_wr[w_idx] ? 1'b1 : r_clr_full;
        w_low   = '0;
        w_found = 1'b0;
        for (int i = NSLOTS - 1; i >= 0; i--) begin
            if (!r_slot_used[i]) begin
                w_low   = SW'(i);
                w_found = 1'b1;
            end
        end
    end

    // Read-modify-write step
    always_comb begin
        n_state     = r_state;
        n_slot_used = r_slot_used;
        n_remap_wr  = r_remap_wr;
        n_clr_full  = r_clr_full;
        n_tgt       = r_tgt;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_remap_we  = 1'b0;
        w_entry_we  = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out       = '0;
                n_out_valid = 1'b1;
                case (r_in.op)
                    OP_CLEAR: begin
                        n_remap_wr = '0;
                        n_clr_full = r_in.primary;
                        if (r_in.primary) begin
                            n_slot_used = '0;
                        end
                    end
                    OP_DECL: begin
                        if (w_inr && !r_slot_used[w_idx]) begin
                            n_tgt      = w_idx;
                            w_entry_we = 1'b1;
                        end else if (w_inr && w_set) begin
                            n_out.status = ST_REDECL;
                        end else if (w_found) begin
                            n_tgt      = w_low;
                            w_entry_we = 1'b1;
                            if (w_inr) begin
                                w_remap_we        = 1'b1;
                                n_remap_wr[w_idx] = 1'b1;
                            end
                        end else begin
                            n_out.status = ST_FULL;
                        end
                        if (w_entry_we) begin
                            n_slot_used[n_tgt] = 1'b1;
                            n_out.slot         = 4'(n_tgt);
                        end
                    end
                    OP_MAP: begin
                        n_out.mapped_var = 5'(r_in.var_no);
                        if (w_inr && w_set) begin
                            n_out.mapped_var = r_remap_wr[w_idx] ? 5'(r_rd) : 5'(FULL_MARK);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot_used <= '0;
            r_remap_wr  <= '0;
            r_clr_full  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot_used <= n_slot_used;
            r_remap_wr  <= n_remap_wr;
            r_clr_full  <= n_clr_full;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in.data;
        end
        r_tgt <= n_tgt;
        r_out <= n_out;
    end

    // Remap memory: read on accept, written in the execute cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= remap_mem[SW'(i_in.data.var_no)];
        end
        if (w_remap_we) begin
            remap_mem[w_idx] <= RW'(w_low);
        end
    end

    // Entry store: name, owner, status of each declared slot
    always_ff @(posedge i_clk) begin
        if (w_entry_we) begin
            entry_mem[n_tgt] <= {w_name[NW-1:0], r_in.owner_code, r_in.rel_status};
        end
    end

    // Result is valid once the execute step that follows acceptance has been registered
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##2 r_out_valid)
        else $error("result not registered two cycles after accept");

    // A successful declare leaves its slot in use
    a_decl_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_in.op == OP_DECL && r_out.status == ST_OK)
        |-> r_slot_used[r_tgt])
        else $error("declared slot not marked used");

    // Table full only when no slot is free
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_out.status == ST_FULL) |-> (&r_slot_used))
        else $error("table full reported with a free slot");

    // No new transaction while one is executing
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !w_accept)
        else $error("accept during execute cycle");

endmodule
